FILE: rtl/tkr_pkg.sv
// ----------------------------------------------------------------------------
// tkr_pkg
// Shared constants and controller/datapath interface types for the top-k
// record selector.
// ----------------------------------------------------------------------------
package tkr_pkg;

    localparam int DEPTH     = 16;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int RANK_W    = 4;
    localparam int MAX_OUT   = 16;
    localparam int ADDR_W    = 64;
    localparam int SIZE_W    = 64;
    localparam int KIND_IN_W = 8;
    localparam int KIND_W    = 4;
    localparam int LINE_IN_W = 32;
    localparam int LINE_W    = 20;
    localparam int SHOW_W    = 5;
    localparam int LIMIT_W   = 21;

    localparam logic [LIMIT_W-1:0]   LIMIT_CAP   = LIMIT_W'(1048576);
    localparam logic [LINE_IN_W-1:0] LINE_MAX_OK = LINE_IN_W'(1000000);
    localparam logic [KIND_IN_W-1:0] KIND_MAX_OK = KIND_IN_W'(8);

    // Register indexes on the configuration port
    localparam logic REG_SHOW_COUNT   = 1'b0;
    localparam logic REG_RECORD_LIMIT = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic              insert;      // take the input record into the chain
        logic              pop;         // move entry 0 to the output register
        logic              pop_last;    // popped entry closes the run
        logic              load_empty;  // load the empty-set result
        logic              clear;       // drop every held entry
        logic [RANK_W-1:0] rank;        // rank of the popped entry
    } tkr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [COUNT_W-1:0] held_count;
        logic               out_free;
    } tkr_stat_t;

endpackage

FILE: rtl/top_k_records_by_size_top.sv
// ----------------------------------------------------------------------------
// top_k_records_by_size_top
// Streaming selector that keeps the largest allocation records by size and
// emits them in descending order at the end of each record set.
// ----------------------------------------------------------------------------
// Records arrive one item per clock on the input channel while the block is
// collecting; each record is dropped into a 16-cell compare-and-shift chain
// in the same cycle, so a set of N records streams in at one item per cycle.
// Equal sizes keep arrival order (earlier record ranks first). A kind above 8
// and a line above 1000000 are stored as 0, and records past record_limit
// (capped at 1048576) in one set are ignored but still accepted. The item
// marked last_in closes the set: after a sizing state that counts the held
// entries, the chain shifts out one result per cycle into the output
// register while that register is free, for show_count results (all held
// when show_count is 0 or larger than the count). The input stays stalled
// during sizing and emission, and output back-pressure stretches the
// emission. A set with nothing held produces one result with is_empty and
// last_out set and every other field zero. Configuration is written over
// the APB port while idle: show_count at 0x0, record_limit at 0x4.
// ----------------------------------------------------------------------------
module top_k_records_by_size_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                has_entry,
    input  logic [tkr_pkg::ADDR_W-1:0]          entry_address,
    input  logic [tkr_pkg::SIZE_W-1:0]          entry_size,
    input  logic [tkr_pkg::KIND_IN_W-1:0]       entry_kind,
    input  logic [tkr_pkg::LINE_IN_W-1:0]       entry_line,
    input  logic                                last_in,
    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tkr_pkg::ADDR_W-1:0]          out_address,
    output logic [tkr_pkg::SIZE_W-1:0]          out_size,
    output logic [tkr_pkg::KIND_W-1:0]          out_kind,
    output logic [tkr_pkg::LINE_W-1:0]          out_line,
    output logic [tkr_pkg::RANK_W-1:0]          out_rank,
    output logic                                is_empty,
    output logic                                last_out
);

    logic [tkr_pkg::SHOW_W-1:0]   show_count_reg;
    logic [tkr_pkg::SHOW_W-1:0]   show_count_next;
    logic [tkr_pkg::LIMIT_W-1:0]  record_limit_reg;
    logic [tkr_pkg::LIMIT_W-1:0]  record_limit_next;
    logic                         cfg_write;
    logic                         cfg_index;

    tkr_pkg::tkr_cmd_t            cmd;
    tkr_pkg::tkr_stat_t           stat;

    // Zero-wait APB: a write lands in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2];

    always_comb
    begin
        show_count_next   = show_count_reg;
        record_limit_next = record_limit_reg;
        if (cfg_write) begin
            case (cfg_index)
                tkr_pkg::REG_SHOW_COUNT:
                begin
                    show_count_next = pwdata[tkr_pkg::SHOW_W-1:0];
                end
                tkr_pkg::REG_RECORD_LIMIT:
                begin
                    record_limit_next = pwdata[tkr_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                    show_count_next = show_count_reg;
                end
            endcase
        end
    end

    // Read back the addressed register, zero-extended
    always_comb
    begin
        case (cfg_index)
            tkr_pkg::REG_SHOW_COUNT:   prdata = 32'(show_count_reg);
            tkr_pkg::REG_RECORD_LIMIT: prdata = 32'(record_limit_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            show_count_reg   <= '0;
            record_limit_reg <= tkr_pkg::LIMIT_CAP;
        end
        else begin
            show_count_reg   <= show_count_next;
            record_limit_reg <= record_limit_next;
        end
    end

    // Sequencer: intake, sizing and emission
    tkr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .show_count   (show_count_reg),
        .record_limit (record_limit_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .has_entry    (has_entry),
        .last_in      (last_in),
        .stat         (stat),
        .cmd          (cmd)
    );

    // Cell chain and output register
    tkr_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .entry_address (entry_address),
        .entry_size    (entry_size),
        .entry_kind    (entry_kind),
        .entry_line    (entry_line),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_address   (out_address),
        .out_size      (out_size),
        .out_kind      (out_kind),
        .out_line      (out_line),
        .out_rank      (out_rank),
        .is_empty      (is_empty),
        .last_out      (last_out)
    );

endmodule

FILE: rtl/tkr_datapath.sv
// ----------------------------------------------------------------------------
// tkr_datapath
// Chain of compare-and-shift cells holding the largest records, plus the
// output register.
// ----------------------------------------------------------------------------
module tkr_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tkr_pkg::tkr_cmd_t                   cmd,
    output tkr_pkg::tkr_stat_t                  stat,
    input  logic [tkr_pkg::ADDR_W-1:0]          entry_address,
    input  logic [tkr_pkg::SIZE_W-1:0]          entry_size,
    input  logic [tkr_pkg::KIND_IN_W-1:0]       entry_kind,
    input  logic [tkr_pkg::LINE_IN_W-1:0]       entry_line,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [tkr_pkg::ADDR_W-1:0]          out_address,
    output logic [tkr_pkg::SIZE_W-1:0]          out_size,
    output logic [tkr_pkg::KIND_W-1:0]          out_kind,
    output logic [tkr_pkg::LINE_W-1:0]          out_line,
    output logic [tkr_pkg::RANK_W-1:0]          out_rank,
    output logic                                is_empty,
    output logic                                last_out
);

    typedef struct packed {
        logic [tkr_pkg::ADDR_W-1:0] address;
        logic [tkr_pkg::SIZE_W-1:0] size;
        logic [tkr_pkg::KIND_W-1:0] kind;
        logic [tkr_pkg::LINE_W-1:0] line;
    } entry_t;

    entry_t                       cell_reg   [tkr_pkg::DEPTH];
    entry_t                       cell_next  [tkr_pkg::DEPTH];
    logic [tkr_pkg::DEPTH-1:0]    valid_reg;
    logic [tkr_pkg::DEPTH-1:0]    valid_next;
    logic [tkr_pkg::DEPTH-1:0]    keep;
    logic [tkr_pkg::DEPTH-1:0]    order_ok;
    entry_t                       new_entry;
    logic [tkr_pkg::COUNT_W-1:0]  count;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    entry_t                       out_entry_reg;
    entry_t                       out_entry_next;
    logic [tkr_pkg::RANK_W-1:0]   out_rank_reg;
    logic [tkr_pkg::RANK_W-1:0]   out_rank_next;
    logic                         is_empty_reg;
    logic                         is_empty_next;
    logic                         last_out_reg;
    logic                         last_out_next;

    // Clamp kind and line of the incoming record
    always_comb
    begin
        new_entry.address = entry_address;
        new_entry.size    = entry_size;
        new_entry.kind    = (entry_kind > tkr_pkg::KIND_MAX_OK) ? '0
                                : tkr_pkg::KIND_W'(entry_kind);
        new_entry.line    = (entry_line > tkr_pkg::LINE_MAX_OK) ? '0
                                : tkr_pkg::LINE_W'(entry_line);
    end

    // A cell keeps its entry when it is at least as large (earlier wins ties)
    always_comb
    begin
        for (int i = 0; i < tkr_pkg::DEPTH; i++) begin
            keep[i] = valid_reg[i] && (cell_reg[i].size >= entry_size);
        end
    end

    always_comb
    begin
        cell_next  = cell_reg;
        valid_next = valid_reg;
        if (cmd.clear) begin
            valid_next = '0;
        end
        else if (cmd.pop) begin
            for (int i = 0; i < tkr_pkg::DEPTH - 1; i++) begin
                cell_next[i]  = cell_reg[i+1];
                valid_next[i] = valid_reg[i+1];
            end
            valid_next[tkr_pkg::DEPTH-1] = 1'b0;
        end
        else if (cmd.insert) begin
            for (int i = 0; i < tkr_pkg::DEPTH; i++) begin
                if (!keep[i]) begin
                    if (i == 0) begin
                        cell_next[i]  = new_entry;
                        valid_next[i] = 1'b1;
                    end
                    else if (keep[i-1]) begin
                        cell_next[i]  = new_entry;
                        valid_next[i] = 1'b1;
                    end
                    else begin
                        cell_next[i]  = cell_reg[i-1];
                        valid_next[i] = valid_reg[i-1];
                    end
                end
            end
        end
    end

    // Valid bits form a prefix, so the count is their population
    always_comb
    begin
        count = '0;
        for (int i = 0; i < tkr_pkg::DEPTH; i++) begin
            count = count + tkr_pkg::COUNT_W'(valid_reg[i]);
        end
    end

    // Output register: load on pop or empty result, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_entry_next = out_entry_reg;
        out_rank_next  = out_rank_reg;
        is_empty_next  = is_empty_reg;
        last_out_next  = last_out_reg;
        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.pop) begin
            out_valid_next = 1'b1;
            out_entry_next = cell_reg[0];
            out_rank_next  = cmd.rank;
            is_empty_next  = 1'b0;
            last_out_next  = cmd.pop_last;
        end
        else if (cmd.load_empty) begin
            out_valid_next = 1'b1;
            out_entry_next = '0;
            out_rank_next  = '0;
            is_empty_next  = 1'b1;
            last_out_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg      <= cell_next;
        out_entry_reg <= out_entry_next;
        out_rank_reg  <= out_rank_next;
        is_empty_reg  <= is_empty_next;
        last_out_reg  <= last_out_next;
    end

    assign stat.held_count = count;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_address = out_entry_reg.address;
    assign out_size    = out_entry_reg.size;
    assign out_kind    = out_entry_reg.kind;
    assign out_line    = out_entry_reg.line;
    assign out_rank    = out_rank_reg;
    assign is_empty    = is_empty_reg;
    assign last_out    = last_out_reg;

    // Neighboring valid entries are in descending size order
    always_comb
    begin
        order_ok[0] = 1'b1;
        for (int i = 1; i < tkr_pkg::DEPTH; i++) begin
            order_ok[i] = !valid_reg[i] || (cell_reg[i-1].size >= cell_reg[i].size);
        end
    end

    a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg & ~{valid_reg[tkr_pkg::DEPTH-2:0], 1'b1}) == '0)
        else $error("held entries do not form a prefix");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        &order_ok)
        else $error("held entries out of size order");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && is_empty_reg |-> last_out_reg)
        else $error("empty result not marked last");

    a_no_pop_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop || cmd.load_empty) |-> (!out_valid_reg || out_ready))
        else $error("output register overwritten while held");

endmodule

FILE: rtl/tkr_ctrl.sv
// ----------------------------------------------------------------------------
// tkr_ctrl
// Sequencer for record intake, result emission and store clearing.
// ----------------------------------------------------------------------------
module tkr_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tkr_pkg::SHOW_W-1:0]        show_count,
    input  logic [tkr_pkg::LIMIT_W-1:0]       record_limit,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              has_entry,
    input  logic                              last_in,
    input  tkr_pkg::tkr_stat_t                stat,
    output tkr_pkg::tkr_cmd_t                 cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SIZE,
        S_EMIT
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [tkr_pkg::LIMIT_W-1:0]   taken_reg;
    logic [tkr_pkg::LIMIT_W-1:0]   taken_next;
    logic [tkr_pkg::COUNT_W-1:0]   left_reg;
    logic [tkr_pkg::COUNT_W-1:0]   left_next;
    logic [tkr_pkg::RANK_W-1:0]    rank_reg;
    logic [tkr_pkg::RANK_W-1:0]    rank_next;
    logic [tkr_pkg::LIMIT_W-1:0]   limit;
    logic [tkr_pkg::COUNT_W-1:0]   show_ext;
    logic [tkr_pkg::COUNT_W-1:0]   show;

    assign limit    = (record_limit > tkr_pkg::LIMIT_CAP) ? tkr_pkg::LIMIT_CAP
                                                          : record_limit;
    assign show_ext = tkr_pkg::COUNT_W'(show_count);

    always_comb
    begin
        show = (show_ext != '0 && show_ext < stat.held_count) ? show_ext
                                                              : stat.held_count;
        if (show > tkr_pkg::COUNT_W'(tkr_pkg::MAX_OUT)) begin
            show = tkr_pkg::COUNT_W'(tkr_pkg::MAX_OUT);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        taken_next = taken_reg;
        left_next  = left_reg;
        rank_next  = rank_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.rank   = rank_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (has_entry && taken_reg < limit) begin
                        cmd.insert = 1'b1;
                        taken_next = taken_reg + 1'b1;
                    end
                    if (last_in) begin
                        state_next = S_SIZE;
                    end
                end
            end
            S_SIZE:
            begin
                if (stat.held_count == '0) begin
                    if (stat.out_free) begin
                        cmd.load_empty = 1'b1;
                        cmd.clear      = 1'b1;
                        taken_next     = '0;
                        state_next     = S_IDLE;
                    end
                end
                else begin
                    left_next  = show;
                    rank_next  = '0;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free) begin
                    cmd.pop   = 1'b1;
                    rank_next = rank_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == tkr_pkg::COUNT_W'(1)) begin
                        cmd.pop_last = 1'b1;
                        cmd.clear    = 1'b1;
                        taken_next   = '0;
                        state_next   = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            taken_reg <= '0;
            left_reg  <= '0;
            rank_reg  <= '0;
        end
        else begin
            state_reg <= state_next;
            taken_reg <= taken_next;
            left_reg  <= left_next;
            rank_reg  <= rank_next;
        end
    end

    a_taken_capped: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg <= tkr_pkg::LIMIT_CAP)
        else $error("record count past its cap");

    a_emit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> left_reg != '0)
        else $error("emitting with nothing left to emit");

endmodule

FILE: tb/top_k_records_by_size_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_records_by_size_checker
// Watches the configuration port and both channels of the top-k selector,
// ranks the records of each set on its own and compares every emitted result
// field by field with the oldest ranking still owed.
// ----------------------------------------------------------------------------
module top_k_records_by_size_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic                            has_entry,
    input  logic [tkr_pkg::ADDR_W-1:0]      entry_address,
    input  logic [tkr_pkg::SIZE_W-1:0]      entry_size,
    input  logic [tkr_pkg::KIND_IN_W-1:0]   entry_kind,
    input  logic [tkr_pkg::LINE_IN_W-1:0]   entry_line,
    input  logic                            last_in,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [tkr_pkg::ADDR_W-1:0]      out_address,
    input  logic [tkr_pkg::SIZE_W-1:0]      out_size,
    input  logic [tkr_pkg::KIND_W-1:0]      out_kind,
    input  logic [tkr_pkg::LINE_W-1:0]      out_line,
    input  logic [tkr_pkg::RANK_W-1:0]      out_rank,
    input  logic                            is_empty,
    input  logic                            last_out,
    output int                              fails,
    output int                              pending
);
    import tkr_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
    } alloc_rec_t;

    typedef struct {
        logic [ADDR_W-1:0] address;
        logic [SIZE_W-1:0] size;
        logic [KIND_W-1:0] kind;
        logic [LINE_W-1:0] line;
        logic [RANK_W-1:0] rank;
        logic              empty;
        logic              last;
    } ranked_t;

    alloc_rec_t         kept [DEPTH];
    int                 kept_n;
    logic [LIMIT_W-1:0] taken;
    logic [SHOW_W-1:0]  show_cfg;
    logic [LIMIT_W-1:0] limit_cfg;
    ranked_t            ranking_q [$];

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin : predict
        alloc_rec_t         rec;
        ranked_t            want;
        logic [LIMIT_W-1:0] cap;
        int                 show;
        int                 pos;
        int                 i;
        if (!rst_n) begin
            kept_n    = 0;
            taken     = '0;
            show_cfg  = '0;
            limit_cfg = LIMIT_CAP;
            ranking_q.delete();
            fails     = 0;
            pending  <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_SHOW_COUNT)
                    show_cfg = pwdata[SHOW_W-1:0];
                else if (paddr[2] == REG_RECORD_LIMIT)
                    limit_cfg = pwdata[LIMIT_W-1:0];
            end

            if (out_valid && out_ready) begin
                if (ranking_q.size() == 0) begin
                    $error("result with nothing owed: size 0x%0h rank %0d", out_size, out_rank);
                    fails++;
                end
                else begin
                    want = ranking_q.pop_front();
                    check_field("out_address", want.address, out_address);
                    check_field("out_size", want.size, out_size);
                    check_field("out_kind", 64'(want.kind), 64'(out_kind));
                    check_field("out_line", 64'(want.line), 64'(out_line));
                    check_field("out_rank", 64'(want.rank), 64'(out_rank));
                    check_field("is_empty", 64'(want.empty), 64'(is_empty));
                    check_field("last_out", 64'(want.last), 64'(last_out));
                end
            end

            if (in_valid && in_ready) begin
                cap = (limit_cfg > LIMIT_CAP) ? LIMIT_CAP : limit_cfg;
                if (has_entry && taken < cap) begin
                    rec.address = entry_address;
                    rec.size    = entry_size;
                    rec.kind    = (entry_kind > KIND_MAX_OK) ? '0 : entry_kind[KIND_W-1:0];
                    rec.line    = (entry_line > LINE_MAX_OK) ? '0 : entry_line[LINE_W-1:0];
                    // equal sizes go behind, so the earlier record ranks first
                    pos = 0;
                    while (pos < kept_n && kept[pos].size >= rec.size)
                        pos++;
                    if (pos < DEPTH) begin
                        i = (kept_n < DEPTH) ? kept_n : DEPTH - 1;
                        while (i > pos) begin
                            kept[i] = kept[i-1];
                            i--;
                        end
                        kept[pos] = rec;
                        if (kept_n < DEPTH)
                            kept_n++;
                    end
                    taken++;
                end

                if (last_in) begin
                    if (kept_n == 0) begin
                        want = '{default: '0};
                        want.empty = 1'b1;
                        want.last  = 1'b1;
                        ranking_q.push_back(want);
                    end
                    else begin
                        show = (show_cfg != 0 && show_cfg < kept_n) ? show_cfg : kept_n;
                        if (show > MAX_OUT)
                            show = MAX_OUT;
                        for (i = 0; i < show; i++) begin
                            want.address = kept[i].address;
                            want.size    = kept[i].size;
                            want.kind    = kept[i].kind;
                            want.line    = kept[i].line;
                            want.rank    = i[RANK_W-1:0];
                            want.empty   = 1'b0;
                            want.last    = (i + 1 == show);
                            ranking_q.push_back(want);
                        end
                    end
                    kept_n = 0;
                    taken  = '0;
                end
            end
            pending <= ranking_q.size();
        end
    end

endmodule

FILE: tb/top_k_records_by_size_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_records_by_size_top_tb
// Drives record sets into the top-k selector under several register settings
// and lets the checker rank them and compare every result.
// ----------------------------------------------------------------------------
// A short directed part covers empty sets, size and address extremes, ties,
// out-of-range kinds and lines, and bare end markers. Random sets follow, one
// register setting per phase, with lengths that often overflow the store.
// Both channels idle at random except in one calm phase; the receiver holds
// off once for a long stretch so the block fills and stalls its input.
// ----------------------------------------------------------------------------
module top_k_records_by_size_top_tb;
    import tkr_pkg::*;

    localparam int IDLE_PCT     = 38;    // chance of an idle cycle per side
    localparam int HOLD_CYCLES  = 90;    // one long receiver hold-off
    localparam int HOLD_AFTER   = 200;   // items taken before the hold-off
    localparam int PHASE_ITEMS  = 58;
    localparam int SETTLE       = 4;     // spare cycles before the next register write
    localparam int QUIET_LIMIT  = 1000;  // cycles with no handshake at all

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [2:0]             paddr;
    logic [31:0]            pwdata;
    logic [31:0]            prdata;
    logic                   pready;
    logic                   in_valid;
    logic                   in_ready;
    logic                   has_entry;
    logic [ADDR_W-1:0]      entry_address;
    logic [SIZE_W-1:0]      entry_size;
    logic [KIND_IN_W-1:0]   entry_kind;
    logic [LINE_IN_W-1:0]   entry_line;
    logic                   last_in;
    logic                   out_valid;
    logic                   out_ready;
    logic [ADDR_W-1:0]      out_address;
    logic [SIZE_W-1:0]      out_size;
    logic [KIND_W-1:0]      out_kind;
    logic [LINE_W-1:0]      out_line;
    logic [RANK_W-1:0]      out_rank;
    logic                   is_empty;
    logic                   last_out;

    int fail_count;
    int pending;
    int items_taken;
    bit calm;        // no idling on either side while set

    top_k_records_by_size_top u_dut (.*);

    top_k_records_by_size_checker u_checker (
        .fails   (fail_count),
        .pending (pending),
        .*
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Count accepted items; the receiver uses it to time its hold-off.
    always @(posedge clk) begin
        if (!rst_n)
            items_taken <= 0;
        else if (in_valid && in_ready)
            items_taken <= items_taken + 1;
    end

    // Offer one item, with random idle cycles first, and hold it until taken.
    task automatic send_item(input logic has, input logic [63:0] addr,
                             input logic [63:0] size, input logic [7:0] kind,
                             input logic [31:0] line, input logic last);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        has_entry     <= has;
        entry_address <= addr;
        entry_size    <= size;
        entry_kind    <= kind;
        entry_line    <= line;
        last_in       <= last;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Random set: sizes drawn so that ties, extremes and full-range values
    // all show up; kinds and lines straddle their clamp points.
    task automatic send_set(input int len);
        logic        has;
        logic [63:0] size;
        logic [7:0]  kind;
        logic [31:0] line;
        int          pick;
        for (int j = 0; j < len; j++) begin
            has  = (j == len - 1) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 9) != 0);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                size = 64'($urandom_range(0, 15));
            else if (pick < 5)
                size = '1;
            else if (pick < 6)
                size = '0;
            else
                size = {$urandom, $urandom};
            kind = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 8)) : 8'($urandom);
            pick = $urandom_range(0, 3);
            if (pick < 2)
                line = $urandom_range(999990, 1000010);
            else if (pick < 3)
                line = $urandom_range(0, 1000000);
            else
                line = $urandom;
            send_item(has, {$urandom, $urandom}, size, kind, line, j == len - 1);
        end
    endtask

    // Drop valid and wait until every owed result is out, then idle a few
    // spare cycles.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands on the access edge.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random stalls, none in the calm phase, and one long hold-off
    // while the sender keeps offering sets.
    initial begin : receiver
        bit held_off;
        held_off  = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (!held_off && items_taken >= HOLD_AFTER) begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if nothing moves on any port for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("top_k_records_by_size_top: mismatch");
        $finish;
    end

    initial begin : stimulus
        int phase_end;
        calm          = 1'b0;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        has_entry     <= 1'b0;
        entry_address <= '0;
        entry_size    <= '0;
        entry_kind    <= '0;
        entry_line    <= '0;
        last_in       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset settings (show all, full limit).
        // Bare end marker on an empty store: one empty result.
        send_item(1'b0, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), $urandom, 1'b1);
        // Extremes: zero and all-ones fields, ties on size, kinds 8/9/255,
        // lines at and past the clamp point, a record on the closing item.
        send_item(1'b1, 64'h0, 64'h0, 8'd0, 32'd0, 1'b0);
        send_item(1'b1, '1, '1, 8'd8, 32'd1000000, 1'b0);
        send_item(1'b1, 64'h0123_4567_89AB_CDEF, 64'd100, 8'd9, 32'd1000001, 1'b0);
        send_item(1'b1, 64'hFEDC_BA98_7654_3210, 64'd100, 8'd255, 32'hFFFF_FFFF, 1'b0);
        send_item(1'b1, 64'h5555_AAAA_5555_AAAA, '1, 8'd1, 32'd999999, 1'b0);
        send_item(1'b1, 64'hAAAA_5555_AAAA_5555, 64'd5, 8'd7, 32'd1, 1'b0);
        send_item(1'b1, 64'h8000_0000_0000_0001, 64'd100, 8'd4, 32'd524288, 1'b1);
        // Bare items inside a set are ignored; the set closes on a bare marker.
        send_item(1'b1, 64'h1111, 64'd50, 8'd2, 32'd10, 1'b0);
        send_item(1'b0, {$urandom, $urandom}, '1, 8'd3, 32'd20, 1'b0);
        send_item(1'b1, 64'h2222, 64'd60, 8'd6, 32'd30, 1'b0);
        send_item(1'b0, {$urandom, $urandom}, '1, 8'd5, 32'd40, 1'b1);

        // Random phases, each under its own register setting.
        for (int p = 1; p <= 7; p++) begin
            drain();
            case (p)
                1: begin
                    write_reg(REG_SHOW_COUNT, 32'd1);
                    write_reg(REG_RECORD_LIMIT, 32'd1048576);
                end
                2: begin
                    // nothing is kept: every set ends empty
                    write_reg(REG_SHOW_COUNT, 32'd16);
                    write_reg(REG_RECORD_LIMIT, 32'd0);
                end
                3: begin
                    // show above any count, limit above the cap
                    write_reg(REG_SHOW_COUNT, 32'd31);
                    write_reg(REG_RECORD_LIMIT, 32'h001F_FFFF);
                end
                4: begin
                    write_reg(REG_SHOW_COUNT, 32'd0);
                    write_reg(REG_RECORD_LIMIT, 32'd1);
                end
                5: begin
                    write_reg(REG_SHOW_COUNT, 32'd3);
                    write_reg(REG_RECORD_LIMIT, 32'd5);
                end
                6: begin
                    // upper bits random to exercise the register widths
                    write_reg(REG_SHOW_COUNT, ($urandom & ~32'h1F) | $urandom_range(0, 31));
                    write_reg(REG_RECORD_LIMIT,
                              ($urandom & ~32'h1F_FFFF) | $urandom_range(0, 40));
                end
                default: begin
                    write_reg(REG_SHOW_COUNT, 32'd0);
                    write_reg(REG_RECORD_LIMIT, 32'd1048576);
                end
            endcase
            calm      = (p == 3);
            phase_end = items_taken + PHASE_ITEMS;
            while (items_taken < phase_end)
                send_set(($urandom_range(0, 3) == 0) ? $urandom_range(17, 30)
                                                     : $urandom_range(1, 12));
        end
        calm = 1'b0;

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("top_k_records_by_size_top: match");
        else
            $display("top_k_records_by_size_top: mismatch");
        $finish;
    end

endmodule

FILE: files.f
rtl/tkr_pkg.sv
rtl/tkr_datapath.sv
rtl/tkr_ctrl.sv
rtl/top_k_records_by_size_top.sv
tb/top_k_records_by_size_checker.sv
tb/top_k_records_by_size_top_tb.sv
